// ===== sv/efve_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder frame velocity estimator package
// Shared widths, constants, register indexes, sequencer states and the
// angle reduction table.
// ----------------------------------------------------------------------------
package efve_pkg;

  // Field widths.
  localparam int ANGLE_W  = 7;
  localparam int BYTE_W   = 8;
  localparam int VEL_W    = 38;
  localparam int SCALE_W  = 40;
  localparam int REVSPD_W = 16;
  localparam int TICK_W   = 32;
  localparam int DIVR_W   = TICK_W + 1;
  localparam int DIFF_W   = ANGLE_W + 2;

  // Angle segments per turn and half a turn.
  localparam int ANGLE_STEPS = 128;
  localparam int ANGLE_HALF  = ANGLE_STEPS / 2;

  // Frame bytes.
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hff;

  // Register reset values.
  localparam logic [SCALE_W-1:0]  RATE_SCALE_RESET     = 40'd77207781048;
  localparam logic [REVSPD_W-1:0] REVERSAL_SPEED_RESET = 16'd655;

  // Largest speed magnitude and the divider step count.
  localparam int SPEED_MAG_W = VEL_W - 1;
  localparam logic [SPEED_MAG_W-1:0] SPEED_MAX = '1;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam int DIV_STEPS = SCALE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_RATE_SCALE     = 1'b0,
    CFG_REVERSAL_SPEED = 1'b1
  } cfg_index_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_STORE,
    ST_MED_A,
    ST_MED_B,
    ST_OUT
  } state_t;

  // Raw angle reduced into the turn, one entry per 7-bit code.
  typedef logic [ANGLE_W-1:0] angle_tab_t [2**ANGLE_W];

  function automatic angle_tab_t build_angle_tab();
    angle_tab_t t;
    for (int i = 0; i < 2**ANGLE_W; i++) begin
      t[i] = ANGLE_W'(i % ANGLE_STEPS);
    end
    return t;
  endfunction

  localparam angle_tab_t ANGLE_TAB = build_angle_tab();

endpackage

// ===== sv/encoder_frame_velocity_estimator.sv =====
// A tick or a byte that does not close a frame leaves the sequencer idle.
// A frame that needs a speed division steps through the divider, scale, store,
// median and output states; a reversal frame starts at store, a reset at output.
// Frames share one 40-step restoring divider; no input is taken until idle again.
// Reset is synchronous and active high; it clears all motion state.
// ----------------------------------------------------------------------------
// Encoder frame velocity estimator
// Pairs received bytes into encoder frames, derives a period-based speed per
// channel with one shared bit-serial divider and median-filters three samples.
// ----------------------------------------------------------------------------
module encoder_frame_velocity_estimator (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]                      s_axis_tuser,   // [0] mode
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [55:0]                     m_axis_tdata,   // [6:0] angle,
                                                          // [14:7] raw_rate,
                                                          // [52:15] velocity
  output logic [1:0]                      m_axis_tuser,   // [0] channel,
                                                          // [1] was_reset
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  efve_pkg::cfg_index_t            cfg_addr,
  input  logic [efve_pkg::SCALE_W-1:0]    cfg_data
);
  import efve_pkg::*;

  // Configuration registers.
  logic [SCALE_W-1:0]  rate_scale;
  logic [REVSPD_W-1:0] reversal_speed;

  // Frame and motion state.
  logic [BYTE_W-1:0]         first_byte;
  logic                      have_first;
  logic [ANGLE_W-1:0]        last_angle [2];
  logic signed [VEL_W-1:0]   filtered_speed [2];
  logic signed [VEL_W-1:0]   speed_history [2][3];
  logic [1:0]                history_slot [2];
  logic [TICK_W-1:0]         tick_count [2];

  // Sequencer and working registers.
  state_t                    state, state_next;
  logic                      ch;
  logic                      neg;
  logic [DIVR_W-1:0]         divisor;
  logic [DIVR_W-1:0]         rem;
  logic [SCALE_W-1:0]        quo;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic signed [VEL_W-1:0]   sample;
  logic signed [VEL_W-1:0]   med_lo;
  logic signed [VEL_W-1:0]   med_hi;
  logic                      res_reset;
  logic [ANGLE_W-1:0]        res_angle;
  logic [BYTE_W-1:0]         res_rate;
  logic signed [VEL_W-1:0]   res_vel;

  // Decoded input transaction.
  logic                      in_fire;
  logic                      is_tick;
  logic [BYTE_W-1:0]         rx;
  logic                      resync;
  logic                      reset_frame;
  logic                      frame_ch;
  logic [ANGLE_W-1:0]        raw;
  logic signed [DIFF_W-1:0]  diff;
  logic                      fs_neg;
  logic                      fs_pos;
  logic                      reversal;
  logic                      out_free;
  logic [DIVR_W:0]           rem_shift;
  logic [DIVR_W:0]           trial;
  logic [SPEED_MAG_W-1:0]    mag;
  logic signed [VEL_W-1:0]   med_c;
  logic signed [VEL_W-1:0]   med;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = s_axis_tuser[0];
  assign rx            = s_axis_tdata;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Frame decode, angle step with wrap, and reversal detection.
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    resync      = (rx == SYNC_BYTE) && (first_byte != SYNC_BYTE);
    reset_frame = (rx == SYNC_BYTE) && (first_byte == SYNC_BYTE);
    frame_ch    = first_byte[BYTE_W-1];
    raw         = ANGLE_TAB[first_byte[ANGLE_W-1:0]];
    d = $signed({2'b00, raw}) - $signed({2'b00, last_angle[frame_ch]});
    if (frame_ch) begin
      d = -d;
    end
    if (d < -DIFF_W'(ANGLE_HALF)) begin
      d = d + DIFF_W'(ANGLE_STEPS);
    end
    if (d > DIFF_W'(ANGLE_HALF)) begin
      d = d - DIFF_W'(ANGLE_STEPS);
    end
    diff     = d;
    fs_neg   = filtered_speed[frame_ch] < 0;
    fs_pos   = filtered_speed[frame_ch] > 0;
    reversal = (fs_neg && (diff > 0)) || (fs_pos && (diff < 0));
  end

  // Divider step, quotient saturation and median selection.
  always_comb begin
    rem_shift = {rem, quo[SCALE_W-1]};
    trial     = rem_shift - {1'b0, divisor};
    mag       = (quo > SCALE_W'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_MAG_W-1:0];
    med_c     = speed_history[ch][2];
    if (med_c <= med_lo) begin
      med = med_lo;
    end else if (med_c >= med_hi) begin
      med = med_hi;
    end else begin
      med = med_c;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && !is_tick && have_first && !resync) begin
          if (reset_frame) begin
            state_next = ST_OUT;
          end else if (reversal) begin
            state_next = ST_STORE;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(1)) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: state_next = ST_STORE;
      ST_STORE: state_next = ST_MED_A;
      ST_MED_A: state_next = ST_MED_B;
      ST_MED_B: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale     <= RATE_SCALE_RESET;
      reversal_speed <= REVERSAL_SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_RATE_SCALE:     rate_scale     <= cfg_data;
        CFG_REVERSAL_SPEED: reversal_speed <= cfg_data[REVSPD_W-1:0];
      endcase
    end
  end

  // Frame assembly, motion state, tick counters and the speed datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte <= '0;
      have_first <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        last_angle[c]     <= '0;
        filtered_speed[c] <= '0;
        history_slot[c]   <= '0;
        tick_count[c]     <= '0;
        for (int k = 0; k < 3; k++) begin
          speed_history[c][k] <= '0;
        end
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_tick) begin
              for (int c = 0; c < 2; c++) begin
                if (tick_count[c] != TICK_MAX) begin
                  tick_count[c] <= tick_count[c] + 1'b1;
                end
              end
            end else if (!have_first) begin
              first_byte <= rx;
              have_first <= 1'b1;
            end else if (resync) begin
              first_byte <= rx;
            end else begin
              have_first <= 1'b0;
              if (reset_frame) begin
                for (int c = 0; c < 2; c++) begin
                  last_angle[c]     <= '0;
                  filtered_speed[c] <= '0;
                  history_slot[c]   <= '0;
                  for (int k = 0; k < 3; k++) begin
                    speed_history[c][k] <= '0;
                  end
                end
              end else begin
                last_angle[frame_ch] <= raw;
                tick_count[frame_ch] <= '0;
              end
            end
          end
        end
        ST_STORE: begin
          if (history_slot[ch] > 2'd2) begin
            speed_history[ch][0] <= sample;
            history_slot[ch]     <= 2'd1;
          end else begin
            speed_history[ch][history_slot[ch]] <= sample;
            history_slot[ch] <= (history_slot[ch] == 2'd2) ? 2'd0
                                                           : history_slot[ch] + 2'd1;
          end
        end
        ST_MED_B: begin
          filtered_speed[ch] <= med;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the shared divider and filter; no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire && !is_tick && have_first && !resync) begin
          neg       <= diff < 0;
          divisor   <= {1'b0, tick_count[frame_ch]} + DIVR_W'(1);
          rem       <= '0;
          quo       <= rate_scale;
          div_cnt   <= DIV_CNT_W'(DIV_STEPS);
          res_reset <= reset_frame;
          if (reset_frame) begin
            ch        <= 1'b0;
            res_angle <= '0;
            res_rate  <= '0;
            res_vel   <= '0;
          end else begin
            ch       <= frame_ch;
            res_rate <= rx;
            if (frame_ch && (raw != '0)) begin
              res_angle <= ANGLE_W'(ANGLE_STEPS - int'(raw));
            end else begin
              res_angle <= raw;
            end
          end
          if (fs_neg) begin
            sample <= VEL_W'(reversal_speed);
          end else begin
            sample <= -VEL_W'(reversal_speed);
          end
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt - 1'b1;
        if (!trial[DIVR_W]) begin
          rem <= trial[DIVR_W-1:0];
          quo <= {quo[SCALE_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift[DIVR_W-1:0];
          quo <= {quo[SCALE_W-2:0], 1'b0};
        end
      end
      ST_SCALE: begin
        if (neg) begin
          sample <= -$signed({1'b0, mag});
        end else begin
          sample <= $signed({1'b0, mag});
        end
      end
      ST_MED_A: begin
        if (speed_history[ch][0] < speed_history[ch][1]) begin
          med_lo <= speed_history[ch][0];
          med_hi <= speed_history[ch][1];
        end else begin
          med_lo <= speed_history[ch][1];
          med_hi <= speed_history[ch][0];
        end
      end
      ST_MED_B: begin
        res_vel <= med;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {3'b000, res_vel, res_rate, res_angle};
      m_axis_tuser <= {res_reset, ch};
    end
  end

  // A reset result carries channel 0 and an all-zero payload.
  a_reset_result_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("reset result with nonzero payload");

  // Speeds are saturated, so the most negative code never appears.
  a_velocity_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[52:15] != {1'b1, {(VEL_W-1){1'b0}}}))
    else $error("velocity out of range");

  // The history slot pointers stay within the three samples.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (history_slot[0] != 2'd3) && (history_slot[1] != 2'd3))
    else $error("history slot out of range");

  // The divider never runs with a zero divisor or an exhausted count.
  a_div_operands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (divisor != '0 && div_cnt != '0))
    else $error("divider started with bad operands");

  // A frame that closes without a reversal or a reset enters the divider next.
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_fire && !is_tick && have_first && !resync &&
     !reset_frame && !reversal) |=> (state == ST_DIV && div_cnt == DIV_CNT_W'(DIV_STEPS)))
    else $error("divider not started for a frame");

endmodule

// ===== verif/tb_encoder_frame_velocity_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder frame velocity estimator testbench
// Streams received bytes and timebase ticks into the block and tracks the
// frame pairing, angle steps, period-based speeds and the three-sample median
// in a behavioral copy of the estimator. Every result transaction is checked
// field by field against the oldest predicted frame. Traffic arrives in
// bursts, the result side stalls on its own pattern, and the run covers the
// register extremes between phases.
// ----------------------------------------------------------------------------
module tb_encoder_frame_velocity_estimator;
  import efve_pkg::*;

  // Input item kinds carried in tuser.
  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } rx_mode_t;

  typedef struct packed {
    rx_mode_t   mode;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic               channel;
    logic               was_reset;
    logic [ANGLE_W-1:0] angle;
    logic [7:0]         raw_rate;
    logic [VEL_W-1:0]   velocity;
  } frame_result_t;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 1500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_addr = CFG_RATE_SCALE;
  logic [SCALE_W-1:0] cfg_data = '0;

  encoder_frame_velocity_estimator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // Estimator copy: registers and per-channel motion state.
  logic [SCALE_W-1:0]  scale_setting    = RATE_SCALE_RESET;
  logic [REVSPD_W-1:0] reversal_setting = REVERSAL_SPEED_RESET;
  logic [7:0]          held_byte        = '0;
  logic                held_valid       = 1'b0;
  logic [ANGLE_W-1:0]  prev_angle [2]   = '{default: '0};
  longint              smooth_speed [2] = '{default: 0};
  longint              speed_hist [6]   = '{default: 0};
  int                  hist_slot [2]    = '{default: 0};
  logic [TICK_W-1:0]   ticks_since [2]  = '{default: '0};

  rx_item_t      pending_items [$];
  frame_result_t predicted_frames [$];
  frame_result_t want;
  rx_item_t      next_item;

  int errors       = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int hold_left    = 0;
  logic hold_done  = 1'b0;

  // Stimulus shaping: intended angle and direction of travel per channel.
  logic [ANGLE_W-1:0] aim [2]     = '{default: '0};
  int                 heading [2] = '{1, 1};

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the estimator copy by one accepted item and queue any result.
  task automatic track_encoder(input rx_mode_t mode, input logic [7:0] rx);
    logic [7:0]         lead;
    logic               ch;
    logic [ANGLE_W-1:0] raw;
    int                 step;
    longint unsigned    quo;
    longint             spd;
    longint             a;
    longint             b;
    longint             c;
    longint             lo;
    longint             hi;
    longint             mid;
    frame_result_t      res;
    if (mode == MODE_TICK) begin
      for (int i = 0; i < 2; i++) begin
        if (ticks_since[i] != TICK_MAX) ticks_since[i]++;
      end
      return;
    end
    if (!held_valid) begin
      held_byte  = rx;
      held_valid = 1'b1;
      return;
    end
    // A sync byte after a plain first byte restarts the frame.
    if (rx == SYNC_BYTE && held_byte != SYNC_BYTE) begin
      held_byte = rx;
      return;
    end
    lead       = held_byte;
    held_valid = 1'b0;

    // The reset frame clears all motion state but keeps the tick counts.
    if (lead == SYNC_BYTE && rx == SYNC_BYTE) begin
      for (int i = 0; i < 2; i++) begin
        prev_angle[i]   = '0;
        smooth_speed[i] = 0;
        hist_slot[i]    = 0;
      end
      for (int i = 0; i < 6; i++) speed_hist[i] = 0;
      res           = '0;
      res.was_reset = 1'b1;
      predicted_frames.push_back(res);
      return;
    end

    ch   = lead[7];
    raw  = ANGLE_W'(int'(lead[6:0]) % ANGLE_STEPS);
    step = int'(raw) - int'(prev_angle[ch]);
    if (ch) step = -step;
    if (step < -ANGLE_HALF) step += ANGLE_STEPS;
    if (step > ANGLE_HALF) step -= ANGLE_STEPS;
    prev_angle[ch] = raw;

    // Direction reversal gives a small opposite speed; otherwise divide.
    if ((smooth_speed[ch] < 0 && step > 0) || (smooth_speed[ch] > 0 && step < 0)) begin
      spd = (smooth_speed[ch] < 0) ? longint'(reversal_setting) : -longint'(reversal_setting);
    end else begin
      quo = {24'b0, scale_setting} / ({32'b0, ticks_since[ch]} + 64'd1);
      if (quo > SPEED_MAX) quo = SPEED_MAX;
      spd = (step < 0) ? -longint'(quo) : longint'(quo);
    end
    ticks_since[ch] = '0;

    speed_hist[ch * 3 + hist_slot[ch]] = spd;
    hist_slot[ch] = (hist_slot[ch] == 2) ? 0 : hist_slot[ch] + 1;

    a   = speed_hist[ch * 3];
    b   = speed_hist[ch * 3 + 1];
    c   = speed_hist[ch * 3 + 2];
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (c <= lo) ? lo : ((c >= hi) ? hi : c);
    smooth_speed[ch] = mid;

    res.channel   = ch;
    res.was_reset = 1'b0;
    res.angle     = ch ? ANGLE_W'(ANGLE_STEPS - int'(raw)) : raw;
    res.raw_rate  = rx;
    res.velocity  = VEL_W'(mid);
    predicted_frames.push_back(res);
  endtask

  task automatic report_field(input string field, input longint expected_val,
                              input longint actual_val);
    if (expected_val != actual_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, field, expected_val, actual_val);
    end
  endtask

  task automatic push_item(input rx_mode_t mode, input logic [7:0] rx);
    rx_item_t it;
    it.mode    = mode;
    it.rx_byte = rx;
    pending_items.push_back(it);
  endtask

  // Mostly well-formed frames with random content, mixed with ticks,
  // reset frames, resyncs and stray bytes.
  task automatic queue_traffic(input int count);
    int   added;
    int   pick;
    int   stride;
    logic ch;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4)) begin
          push_item(MODE_TICK, 8'($urandom_range(0, 255)));
          added++;
        end
        ch = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) heading[ch] = -heading[ch];
        stride = $urandom_range(0, 5);
        if ($urandom_range(0, 9) == 0) aim[ch] = ANGLE_W'($urandom_range(0, 127));
        else aim[ch] = ANGLE_W'(int'(aim[ch]) + heading[ch] * stride);
        push_item(MODE_BYTE, {ch, aim[ch]});
        push_item(MODE_BYTE, 8'($urandom_range(0, 254)));
        added += 2;
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) begin
          push_item(MODE_TICK, 8'($urandom_range(0, 255)));
          added++;
        end
      end else if (pick < 86) begin
        push_item(MODE_BYTE, SYNC_BYTE);
        push_item(MODE_BYTE, SYNC_BYTE);
        added += 2;
      end else if (pick < 93) begin
        push_item(MODE_BYTE, 8'($urandom_range(0, 254)));
        push_item(MODE_BYTE, SYNC_BYTE);
        push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        added += 3;
      end else begin
        push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        added++;
      end
    end
  endtask

  // Wait for all traffic to be taken and every predicted frame to arrive,
  // then let the divider finish any frame still in flight.
  task automatic settle();
    while (pending_items.size() != 0 || s_axis_tvalid || predicted_frames.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [SCALE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_RATE_SCALE) scale_setting = val;
    else reversal_setting = val[REVSPD_W-1:0];
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames: ignored tick byte, zero step, half-turn steps both
    // ways, a reversal, mirrored channel, sync byte as a first byte, resync,
    // reset frames and a wrap across zero.
    push_item(MODE_TICK, 8'hff);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'h7f);
    push_item(MODE_BYTE, 8'h40);
    push_item(MODE_BYTE, 8'h80);
    push_item(MODE_TICK, 8'h00);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'h01);
    push_item(MODE_BYTE, 8'h80);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'hff);
    push_item(MODE_BYTE, 8'h81);
    push_item(MODE_BYTE, 8'h05);
    push_item(MODE_BYTE, 8'hff);
    push_item(MODE_BYTE, 8'h10);
    push_item(MODE_BYTE, 8'hff);
    push_item(MODE_BYTE, 8'hff);
    push_item(MODE_BYTE, 8'h7f);
    push_item(MODE_BYTE, 8'h55);
    push_item(MODE_BYTE, 8'hff);
    push_item(MODE_BYTE, 8'hff);
    queue_traffic(250);
    settle();

    // Largest numerator saturates the speed; largest reversal speed.
    write_reg(CFG_RATE_SCALE, '1);
    write_reg(CFG_REVERSAL_SPEED, SCALE_W'(16'hffff));
    queue_traffic(230);
    settle();

    // Both registers at zero.
    write_reg(CFG_REVERSAL_SPEED, '0);
    write_reg(CFG_RATE_SCALE, '0);
    queue_traffic(200);
    settle();

    // Random settings.
    write_reg(CFG_RATE_SCALE, {8'($urandom_range(0, 255)), 32'($urandom)});
    write_reg(CFG_REVERSAL_SPEED, SCALE_W'($urandom_range(0, 65535)));
    queue_traffic(250);
    settle();

    if (errors == 0) begin
      $display("encoder_frame_velocity_estimator test passed");
    end else begin
      $display("encoder_frame_velocity_estimator test failed");
    end
    $finish;
  end

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_encoder(rx_mode_t'(s_axis_tuser[0]), s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_item.mode;
          s_axis_tdata  <= next_item.rx_byte;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: one long hold-off to back up the input, then a stall
  // pattern that changes with bits 9:8 of the cycle count.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      case (cycle_count[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= (cycle_count[2:0] == 3'd0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (predicted_frames.size() == 0) begin
        errors++;
        $display("%0t ns: result with no frame predicted, expected none, actual tuser %h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = predicted_frames.pop_front();
        report_field("channel", want.channel, m_axis_tuser[0]);
        report_field("was_reset", want.was_reset, m_axis_tuser[1]);
        report_field("angle", want.angle, m_axis_tdata[6:0]);
        report_field("raw_rate", $signed(want.raw_rate), $signed(m_axis_tdata[14:7]));
        report_field("velocity", $signed(want.velocity), $signed(m_axis_tdata[52:15]));
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("encoder_frame_velocity_estimator test failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
sv/efve_pkg.sv
sv/encoder_frame_velocity_estimator.sv
verif/tb_encoder_frame_velocity_estimator.sv
